// ===== src/max_plus_tile_2x8_assert.svh =====
// Assertion macros shared by the tile RTL.
`ifndef MAX_PLUS_TILE_2X8_ASSERT_SVH
`define MAX_PLUS_TILE_2X8_ASSERT_SVH

`ifndef SYNTHESIS

// Checked property, clocked on clk and held off while rstn is low.
`define MPT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tile assertion failed");

// Same, as an implication: cond on one edge, prop on the next.
`define MPT_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
    else $error("tile assertion failed");

`else

`define MPT_ASSERT(lbl, clk, rstn, prop)
`define MPT_ASSERT_NEXT(lbl, clk, rstn, cond, prop)

`endif

`endif

// ===== src/mpt_pkg.sv =====
package mpt_pkg;

  localparam int unsigned TILE_ROWS = 2;
  localparam int unsigned TILE_COLS = 8;

  // Fixed field counts of the item structs.
  localparam int unsigned ItemRows = 2;
  localparam int unsigned ItemCols = 8;

  localparam int unsigned RowIdxW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int unsigned RowCntW = $clog2(TILE_ROWS + 1);

  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {
    OP_LOAD0 = 2'd0,
    OP_LOAD1 = 2'd1,
    OP_STEP  = 2'd2,
    OP_EMIT  = 2'd3
  } op_e;

  typedef struct packed {
    op_e   operation;
    word_t a_row0;
    word_t a_row1;
    word_t b_col0;
    word_t b_col1;
    word_t b_col2;
    word_t b_col3;
    word_t b_col4;
    word_t b_col5;
    word_t b_col6;
    word_t b_col7;
  } in_item_t;

  typedef struct packed {
    logic  row_index;
    word_t c_col0;
    word_t c_col1;
    word_t c_col2;
    word_t c_col3;
    word_t c_col4;
    word_t c_col5;
    word_t c_col6;
    word_t c_col7;
    logic  last_row;
  } out_item_t;

  typedef word_t row_t  [TILE_COLS];
  typedef word_t col_t  [TILE_ROWS];
  typedef row_t  tile_t [TILE_ROWS];

  // Saturating Q16.16 add.
  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  function automatic col_t item_a(in_item_t it);
    word_t all [ItemRows];
    col_t  a;
    all[0] = it.a_row0;
    all[1] = it.a_row1;
    for (int r = 0; r < TILE_ROWS; r++) begin
      a[r] = all[r];
    end
    return a;
  endfunction

  function automatic row_t item_b(in_item_t it);
    word_t all [ItemCols];
    row_t  b;
    all[0] = it.b_col0;
    all[1] = it.b_col1;
    all[2] = it.b_col2;
    all[3] = it.b_col3;
    all[4] = it.b_col4;
    all[5] = it.b_col5;
    all[6] = it.b_col6;
    all[7] = it.b_col7;
    for (int c = 0; c < TILE_COLS; c++) begin
      b[c] = all[c];
    end
    return b;
  endfunction

  function automatic out_item_t make_out(row_t row, logic idx, logic last);
    word_t     all [ItemCols];
    out_item_t o;
    for (int c = 0; c < ItemCols; c++) begin
      all[c] = '0;
    end
    for (int c = 0; c < TILE_COLS; c++) begin
      all[c] = row[c];
    end
    o.row_index = idx;
    o.c_col0    = all[0];
    o.c_col1    = all[1];
    o.c_col2    = all[2];
    o.c_col3    = all[3];
    o.c_col4    = all[4];
    o.c_col5    = all[5];
    o.c_col6    = all[6];
    o.c_col7    = all[7];
    o.last_row  = last;
    return o;
  endfunction

endpackage

// ===== src/mpt_acc_array.sv =====
// Accumulator tile: load or max-plus update, one item per cycle while fire_i is high.
module mpt_acc_array import mpt_pkg::*; (
  input  logic     clk_i,
  input  logic     fire_i,
  input  in_item_t item_i,
  output tile_t    acc_d_o
);

  tile_t acc_q;
  tile_t acc_d;
  col_t  a;
  row_t  b;
  word_t s;

  always_comb begin
    a = item_a(item_i);
    b = item_b(item_i);
    acc_d = acc_q;
    s = '0;
    if (fire_i) begin
      unique case (item_i.operation)
        OP_LOAD0: begin
          acc_d[0] = b;
        end
        OP_LOAD1: begin
          if (TILE_ROWS > 1) begin
            acc_d[RowIdxW'(1)] = b;
          end
        end
        OP_STEP, OP_EMIT: begin
          for (int r = 0; r < TILE_ROWS; r++) begin
            for (int c = 0; c < TILE_COLS; c++) begin
              s = sat_add(a[r], b[c]);
              if ($signed(s) > $signed(acc_q[r][c])) begin
                acc_d[r][c] = s;
              end
            end
          end
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_d_o = acc_d;

endmodule

// ===== src/mpt_out_buf.sv =====
`include "max_plus_tile_2x8_assert.svh"

// Holds the emitted rows and hands them out one per item, row 0 first.
module mpt_out_buf import mpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  tile_t     rows_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  tile_t                rows_q;
  logic [RowCntW-1:0]   cnt_q, cnt_d;
  logic [RowIdxW-1:0]   idx_q, idx_d;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (cnt_q == '0) || ((cnt_q == RowCntW'(1)) && pop);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = RowCntW'(TILE_ROWS);
      idx_d = '0;
    end else if (pop) begin
      cnt_d = cnt_q - RowCntW'(1);
      idx_d = idx_q + RowIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rows_q <= rows_i;
    end
  end

  assign out_item_o = make_out(rows_q[idx_q], idx_q[0], cnt_q == RowCntW'(1));

  `MPT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= RowCntW'(TILE_ROWS))
  `MPT_ASSERT(a_load_free, clk_i, rst_ni, !load_i || free_o)
  `MPT_ASSERT_NEXT(a_last_drains, clk_i, rst_ni, pop && cnt_q == RowCntW'(1) && !load_i,
                   cnt_q == '0)

endmodule

// ===== src/max_plus_tile_2x8.sv =====
// Max-plus tile, 2 rows x 8 columns, Q16.16 with saturating sums.
// An item is registered in the input register; when it leaves, an emit loads
// the output buffer, which hands out row 0 first, then row 1 once row 0 is taken.
// Loads and steps pass one item per cycle unless an emit is waiting ahead of them;
// an emit waits until the output buffer is empty or handing out its last row.
// Reset clears the valid flags only; accumulators are undefined until loaded.
`include "max_plus_tile_2x8_assert.svh"

module max_plus_tile_2x8 import mpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Input register.
  in_item_t in_q;
  logic     in_valid_q;

  // Item leaves the input register this cycle. An emit needs the output
  // buffer empty, or draining its last row in the same cycle.
  logic     go;
  logic     buf_free;
  logic     accept;
  logic     emit;
  tile_t    acc_next;

  assign emit       = (in_q.operation == OP_EMIT);
  assign go         = in_valid_q && (!emit || buf_free);
  assign in_stall_o = in_valid_q && !go;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  // Loads and max-plus updates; acc_next carries the updated tile so an
  // emit snapshots the values after its own step.
  mpt_acc_array u_acc (
    .clk_i   (clk_i),
    .fire_i  (go),
    .item_i  (in_q),
    .acc_d_o (acc_next)
  );

  mpt_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (go && emit),
    .rows_i      (acc_next),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Stall only while an item is waiting, and only an emit can wait.
  `MPT_ASSERT(a_stall_needs_item, clk_i, rst_ni, !in_stall_o || (in_valid_q && emit))
  // A stalled emit stays in the input register.
  `MPT_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, in_stall_o, in_valid_q && emit)

endmodule

// ===== dv/max_plus_tile_2x8_check.sv =====
module max_plus_tile_2x8_check import mpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        rows_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted accumulator tile and the rows that emits still owe us.
  word_t     acc_tile [TILE_ROWS][TILE_COLS];
  out_item_t rows_due [$];

  initial begin
    fail_count_o = 0;
    rows_due_o   = 0;
  end

  function automatic word_t clamp_add(word_t a, word_t b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (s < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return word_t'(s);
  endfunction

  function automatic word_t a_of(in_item_t it, int r);
    return (r == 0) ? it.a_row0 : it.a_row1;
  endfunction

  function automatic word_t b_of(in_item_t it, int c);
    case (c)
      0: return it.b_col0;
      1: return it.b_col1;
      2: return it.b_col2;
      3: return it.b_col3;
      4: return it.b_col4;
      5: return it.b_col5;
      6: return it.b_col6;
      default: return it.b_col7;
    endcase
  endfunction

  function automatic word_t c_of(out_item_t it, int c);
    case (c)
      0: return it.c_col0;
      1: return it.c_col1;
      2: return it.c_col2;
      3: return it.c_col3;
      4: return it.c_col4;
      5: return it.c_col5;
      6: return it.c_col6;
      default: return it.c_col7;
    endcase
  endfunction

  task automatic flag_field(string name, longint want, longint got);
    if (want != got) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, name, want, got);
      end
    end
  endtask

  // Loads overwrite a row; steps take the max with the saturated sum;
  // an emit also queues both rows, row 0 first.
  task automatic absorb_item(in_item_t it);
    word_t     s;
    out_item_t row_res;
    case (it.operation)
      OP_LOAD0, OP_LOAD1: begin
        if (int'(it.operation) < TILE_ROWS) begin
          for (int c = 0; c < TILE_COLS; c++) begin
            acc_tile[int'(it.operation)][c] = b_of(it, c);
          end
        end
      end
      default: begin
        for (int r = 0; r < TILE_ROWS; r++) begin
          for (int c = 0; c < TILE_COLS; c++) begin
            s = clamp_add(a_of(it, r), b_of(it, c));
            if (s > acc_tile[r][c]) begin
              acc_tile[r][c] = s;
            end
          end
        end
        if (it.operation == OP_EMIT) begin
          for (int r = 0; r < TILE_ROWS; r++) begin
            row_res.row_index = r[0];
            row_res.c_col0    = acc_tile[r][0];
            row_res.c_col1    = acc_tile[r][1];
            row_res.c_col2    = acc_tile[r][2];
            row_res.c_col3    = acc_tile[r][3];
            row_res.c_col4    = acc_tile[r][4];
            row_res.c_col5    = acc_tile[r][5];
            row_res.c_col6    = acc_tile[r][6];
            row_res.c_col7    = acc_tile[r][7];
            row_res.last_row  = (r == TILE_ROWS - 1);
            rows_due.push_back(row_res);
          end
        end
      end
    endcase
  endtask

  task automatic check_row(out_item_t got);
    out_item_t want;
    if (rows_due.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("%0t: unexpected result, row %0d", $realtime, got.row_index);
      end
    end else begin
      want = rows_due.pop_front();
      flag_field("row_index", want.row_index, got.row_index);
      for (int c = 0; c < TILE_COLS; c++) begin
        flag_field($sformatf("c_col%0d", c), c_of(want, c), c_of(got, c));
      end
      flag_field("last_row", want.last_row, got.last_row);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_due.delete();
      for (int r = 0; r < TILE_ROWS; r++) begin
        for (int c = 0; c < TILE_COLS; c++) begin
          acc_tile[r][c] = '0;
        end
      end
    end else begin
      if (in_valid_i && !in_stall_i) begin
        absorb_item(in_item_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_row(out_item_i);
      end
    end
    rows_due_o = rows_due.size();
  end

endmodule

// ===== dv/max_plus_tile_2x8_tb.sv =====
module max_plus_tile_2x8_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpt_pkg::*;

  localparam word_t W_MAX = 32'sh7fff_ffff;
  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t W_ONE = 32'sh0001_0000;  // 1.0 in Q16.16

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_q  = 1'b0;
  in_item_t  in_item_q   = '0;
  logic      out_stall_q = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  int fail_count;
  int rows_due;
  int items_sent  = 0;
  int tx_idle_pct = 0;   // chance per cycle that the sender holds off
  int rx_idle_pct = 0;   // chance per cycle that the receiver stalls

  always #10 clk_i = ~clk_i;

  max_plus_tile_2x8 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_q),
    .out_item_o  (out_item_o)
  );

  max_plus_tile_2x8_check check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_q),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_q),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_q),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .rows_due_o   (rows_due)
  );

  // Receiver side: random stall, redrawn every falling edge.
  always @(negedge clk_i) begin
    out_stall_q <= ($urandom_range(99) < rx_idle_pct);
  end

  function automatic in_item_t item_of(op_e op, word_t a0, word_t a1, row_t b);
    in_item_t it;
    it.operation = op;
    it.a_row0    = a0;
    it.a_row1    = a1;
    it.b_col0    = b[0];
    it.b_col1    = b[1];
    it.b_col2    = b[2];
    it.b_col3    = b[3];
    it.b_col4    = b[4];
    it.b_col5    = b[5];
    it.b_col6    = b[6];
    it.b_col7    = b[7];
    return it;
  endfunction

  // Value mix: rails and near-zero corners for saturation, small Q16.16
  // numbers so the max actually competes, and raw words for bit coverage.
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return -32'sd1;
      4, 5: return word_t'($urandom_range(32'h0014_0000)) - 32'sh000a_0000;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item(op_e op);
    row_t b;
    for (int c = 0; c < TILE_COLS; c++) begin
      b[c] = pick_word();
    end
    return item_of(op, pick_word(), pick_word(), b);
  endfunction

  // Offer one item: optional idle gap, then hold valid and payload until
  // the tile takes it.
  task automatic push_item(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_q <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_q <= 1'b1;
    in_item_q  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Sender goes quiet until every predicted row has come out.
  task automatic drain_rows();
    @(negedge clk_i);
    in_valid_q <= 1'b0;
    while (rows_due != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic directed_items();
    // Both rows loaded first: nothing may read an unloaded accumulator.
    push_item(item_of(OP_LOAD0, W_MAX, W_MIN,
      '{W_MAX, W_MIN, 0, -1, 1, W_ONE, 32'sh7fff, -32'sh0001_8000}));
    push_item(item_of(OP_LOAD1, W_MIN, W_MAX,
      '{-W_ONE, 32'sh0002_8000, W_MIN, W_MAX, 0, 1, -1, 3}));
    // Emit straight after loading; sums sit at the low rail so the
    // loaded values come back unchanged.
    push_item(item_of(OP_EMIT, W_MIN, W_MIN,
      '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN}));
    push_item(item_of(OP_STEP, W_ONE, -32'sh0002_0000,
      '{W_ONE, -W_ONE, 0, 32'sh0000_8000, 2 * W_ONE, -1, 1, 32'sh0003_4000}));
    push_item(item_of(OP_EMIT, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}));
    // High-side saturation.
    push_item(item_of(OP_STEP, W_MAX, W_MAX,
      '{W_MAX, 1, W_ONE, 0, -1, W_MIN, W_MAX, 32'sh4000_0000}));
    push_item(item_of(OP_EMIT, W_MIN, W_MIN,
      '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN}));
    // Low-side saturation against accumulators parked at the low rail.
    push_item(item_of(OP_LOAD0, 0, 0,
      '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN}));
    push_item(item_of(OP_LOAD1, 0, 0,
      '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN}));
    push_item(item_of(OP_STEP, W_MIN, -1,
      '{W_MIN, W_MIN, -1, W_MIN, W_MIN, 0, W_MIN, W_MIN}));
    push_item(item_of(OP_STEP, -1, W_MIN,
      '{-1, W_MIN, W_MIN, -W_ONE, W_MIN, W_MIN, 1, W_MIN}));
    push_item(item_of(OP_EMIT, W_MIN, W_MIN,
      '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN}));
    // Back-to-back emits exercise the output buffer turnaround.
    push_item(item_of(OP_EMIT, W_ONE, -W_ONE,
      '{0, W_ONE, -W_ONE, 1, -1, 2, -2, 5 * W_ONE}));
    push_item(item_of(OP_EMIT, 0, W_ONE,
      '{W_ONE, 0, 0, 0, 0, 0, 0, -4 * W_ONE}));
    // Small fractional values: a real running max across several steps.
    push_item(item_of(OP_LOAD0, 0, 0,
      '{-W_ONE, 0, W_ONE, 32'sh0000_4000, -32'sh0000_4000, 3 * W_ONE, 2, -2}));
    push_item(item_of(OP_LOAD1, 0, 0,
      '{W_ONE, -W_ONE, 0, -3 * W_ONE, 32'sh0001_8000, 0, -2, 2}));
    push_item(item_of(OP_STEP, 32'sh0001_8000, -32'sh0000_8000,
      '{-W_ONE, 0, W_ONE, -2 * W_ONE, 32'sh0000_1000, -1, 1, 0}));
    push_item(item_of(OP_STEP, -W_ONE, 2 * W_ONE,
      '{W_ONE, -3 * W_ONE, 0, 1, -1, 2 * W_ONE, -W_ONE, 32'sh0000_c000}));
    push_item(item_of(OP_EMIT, 0, 0,
      '{-W_ONE, -W_ONE, -W_ONE, -W_ONE, -W_ONE, -W_ONE, -W_ONE, -W_ONE}));
  endtask

  // Mostly well-formed runs (optional reload, zero to five steps, a final emit);
  // the rest is single items of any operation.
  task automatic random_runs(int n);
    int target;
    int steps;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 70) begin
          push_item(random_item(OP_LOAD0));
          push_item(random_item(OP_LOAD1));
        end
        steps = $urandom_range(5);
        repeat (steps) push_item(random_item(OP_STEP));
        push_item(random_item(OP_EMIT));
      end else begin
        push_item(random_item(op_e'($urandom_range(3))));
      end
    end
  endtask

  initial begin
    tx_idle_pct = 26;
    rx_idle_pct = 48;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_items();
    random_runs(200);
    // Let the pipe run dry once before swapping the idle pattern.
    drain_rows();

    tx_idle_pct = 48;
    rx_idle_pct = 26;
    random_runs(200);
    drain_rows();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_runs(200);
    drain_rows();

    // A few more cycles to catch any stray row after the last one.
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && rows_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mpt_pkg.sv
src/mpt_acc_array.sv
src/mpt_out_buf.sv
src/max_plus_tile_2x8.sv
dv/max_plus_tile_2x8_check.sv
dv/max_plus_tile_2x8_tb.sv
